### rtl/mmfs_pkg.sv
`timescale 1ns / 1ps

package mmfs_pkg;

    // Field widths
    localparam int ACT_W    = 2;
    localparam int COORD_W  = 6;
    localparam int ENTRY_W  = 2 * COORD_W;
    localparam int DIST_W   = COORD_W + 1;
    localparam int TOTAL_W  = 14;
    localparam int SEL_W    = 5;

    // Store sizes used as parameter defaults
    localparam int DEF_MAX_HOUSES = 128;
    localparam int DEF_MAX_SHOPS  = 16;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_HOUSE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SHOP   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FINISH = 2'd2;

    localparam logic [SEL_W-1:0]   SEL_RESET = 5'd1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 14'd16383;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HOUSE,
        S_DIST,
        S_ACC,
        S_CMP,
        S_FIND,
        S_FILL,
        S_DONE
    } t_state;

    // Controls from the sequencer to the cost unit
    typedef struct packed {
        logic best_init;
        logic sum_clear;
        logic dist_en;
        logic dist_first;
        logic acc_en;
        logic best_upd;
    } t_cost_ctl;

endpackage

### rtl/mmfs_if.sv
`timescale 1ns / 1ps

interface mmfs_in_if;
    import mmfs_pkg::*;
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;

    modport source (output valid, action, row, col, input ready);
    modport sink   (input valid, action, row, col, output ready);
endinterface

interface mmfs_out_if;
    import mmfs_pkg::*;
    logic               valid;
    logic               ready;
    logic [TOTAL_W-1:0] best_total;
    logic               no_solution;
    logic               overflow_seen;

    modport source (output valid, best_total, no_solution, overflow_seen, input ready);
    modport sink   (input valid, best_total, no_solution, overflow_seen, output ready);
endinterface

interface mmfs_cfg_if;
    import mmfs_pkg::*;
    logic             valid;
    logic             ready;
    logic [SEL_W-1:0] select_count;

    modport source (output valid, select_count, input ready);
    modport sink   (input valid, select_count, output ready);
endinterface

### rtl/mmfs_ram.sv
`timescale 1ns / 1ps

module mmfs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 12,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mmfs_cost.sv
`timescale 1ns / 1ps

module mmfs_cost (
    input  logic                              i_clk,
    input  mmfs_pkg::t_cost_ctl               i_ctl,
    input  logic [mmfs_pkg::ENTRY_W-1:0]      i_house,
    input  logic [mmfs_pkg::ENTRY_W-1:0]      i_shop,
    output logic [mmfs_pkg::TOTAL_W-1:0]      o_best
);
    import mmfs_pkg::*;

    logic [COORD_W-1:0] h_row, h_col, s_row, s_col;
    logic [COORD_W-1:0] d_row, d_col;
    logic [DIST_W-1:0]  hs_dist;
    logic [TOTAL_W:0]   sum_ext;
    logic [DIST_W-1:0]  r_dmin;
    logic [TOTAL_W-1:0] r_sum;
    logic [TOTAL_W-1:0] r_best;

    // Manhattan distance between the current house and shop
    assign h_row = i_house[ENTRY_W-1:COORD_W];
    assign h_col = i_house[COORD_W-1:0];
    assign s_row = i_shop[ENTRY_W-1:COORD_W];
    assign s_col = i_shop[COORD_W-1:0];
    assign d_row = (h_row > s_row) ? (h_row - s_row) : (s_row - h_row);
    assign d_col = (h_col > s_col) ? (h_col - s_col) : (s_col - h_col);
    assign hs_dist = DIST_W'(d_row) + DIST_W'(d_col);

    assign sum_ext = (TOTAL_W + 1)'(r_sum) + (TOTAL_W + 1)'(r_dmin);

    // Track nearest chosen shop for the current house
    always_ff @(posedge i_clk) begin
        if (i_ctl.dist_en) begin
            if (i_ctl.dist_first || (hs_dist < r_dmin)) begin
                r_dmin <= hs_dist;
            end
        end
    end

    // Accumulate the subset total, saturating
    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_clear) begin
            r_sum <= '0;
        end else if (i_ctl.acc_en) begin
            if (sum_ext >= (TOTAL_W + 1)'(TOTAL_MAX)) begin
                r_sum <= TOTAL_MAX;
            end else begin
                r_sum <= sum_ext[TOTAL_W-1:0];
            end
        end
    end

    // Keep the smallest subset total
    always_ff @(posedge i_clk) begin
        if (i_ctl.best_init) begin
            r_best <= TOTAL_MAX;
        end else if (i_ctl.best_upd && (r_sum < r_best)) begin
            r_best <= r_sum;
        end
    end

    assign o_best = r_best;

endmodule

### rtl/min_manhattan_facility_select.sv
`timescale 1ns / 1ps

// Exhaustive p-median facility choice on a 64x64 grid. Each add-house or
// add-shop transaction stores one coordinate pair, and the block is ready
// again on the next cycle. A finish transaction walks every combination of
// select_count shops among those loaded and, for each one, every house
// against every chosen shop through one shared distance/compare unit, one
// distance per cycle. A finish with too few shops, no houses or a zero
// selection skips the walk. The result (smallest total, saturated at 16383)
// sits in an output register; loads are taken while it waits, and the
// stores and overflow flag are cleared as it is issued. Loads into a full
// store are dropped and reported in the next result. The user must write
// select_count only while idle; the block does not enforce it.
module min_manhattan_facility_select #(
    parameter int MAX_HOUSES = mmfs_pkg::DEF_MAX_HOUSES,
    parameter int MAX_SHOPS  = mmfs_pkg::DEF_MAX_SHOPS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mmfs_in_if.sink           i_in,
    mmfs_cfg_if.sink          i_cfg,
    mmfs_out_if.source        o_out
);
    import mmfs_pkg::*;

    localparam int HW  = (MAX_HOUSES > 1) ? $clog2(MAX_HOUSES) : 1;
    localparam int HCW = $clog2(MAX_HOUSES + 1);
    localparam int SW  = (MAX_SHOPS > 1) ? $clog2(MAX_SHOPS) : 1;
    localparam int CW  = $clog2(MAX_SHOPS + 1);
    localparam int XW  = (CW > SEL_W) ? CW : SEL_W;

    t_state r_state, n_state;

    logic [SEL_W-1:0]   r_sel;
    logic [HCW-1:0]     r_hcnt;
    logic [CW-1:0]      r_scnt;
    logic               r_ovf;
    logic [SW-1:0]      r_chosen [MAX_SHOPS];
    logic [HW-1:0]      r_h;
    logic [SW-1:0]      r_j;
    logic [SW-1:0]      r_i;
    logic [SW-1:0]      r_k;
    logic [SW-1:0]      r_val;
    logic               r_fix;
    logic [TOTAL_W-1:0] r_fix_val;
    logic               r_nosol;
    logic               r_ovalid;
    logic [TOTAL_W-1:0] r_obest;
    logic               r_onosol;
    logic               r_oovf;

    logic               in_acc;
    logic               in_ready;
    logic               fin_acc;
    logic               house_room;
    logic               shop_room;
    logic               house_we;
    logic               shop_we;
    logic [XW-1:0]      m_x;
    logic [XW-1:0]      n_x;
    logic               nosol_now;
    logic               go_enum;
    logic               last_j;
    logic               last_h;
    logic               last_k;
    logic [XW-1:0]      lim;
    logic               can_adv;
    logic               out_free;
    logic               out_load;
    logic [SW-1:0]      shop_rd_idx;
    logic [ENTRY_W-1:0] house_q;
    logic [ENTRY_W-1:0] shop_q;
    logic [TOTAL_W-1:0] cost_best;
    t_cost_ctl          cost_ctl;

    // Transaction and status decode
    assign in_acc     = i_in.valid && in_ready;
    assign fin_acc    = in_acc && (i_in.action == ACT_FINISH);
    assign house_room = r_hcnt < HCW'(MAX_HOUSES);
    assign shop_room  = r_scnt < CW'(MAX_SHOPS);
    assign house_we   = in_acc && (i_in.action == ACT_HOUSE) && house_room;
    assign shop_we    = in_acc && (i_in.action == ACT_SHOP) && shop_room;
    assign m_x        = XW'(r_sel);
    assign n_x        = XW'(r_scnt);
    assign nosol_now  = m_x > n_x;
    assign go_enum    = !nosol_now && (r_hcnt != '0) && (r_sel != '0);
    assign last_j     = (XW'(r_j) + XW'(1)) == m_x;
    assign last_h     = (HCW'(r_h) + HCW'(1)) == r_hcnt;
    assign last_k     = (XW'(r_k) + XW'(1)) == m_x;
    assign lim        = (n_x - m_x) + XW'(r_i);
    assign can_adv    = XW'(r_chosen[r_i]) < lim;
    assign out_free   = !r_ovalid || o_out.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (fin_acc) begin
                    n_state = go_enum ? S_HOUSE : S_DONE;
                end
            end
            S_HOUSE: n_state = S_DIST;
            S_DIST: begin
                if (last_j) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: n_state = last_h ? S_CMP : S_HOUSE;
            S_CMP: n_state = S_FIND;
            S_FIND: begin
                if (can_adv) begin
                    n_state = S_FILL;
                end else if (r_i == '0) begin
                    n_state = S_DONE;
                end
            end
            S_FILL: begin
                if (last_k) begin
                    n_state = S_HOUSE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        in_ready    = 1'b0;
        out_load    = 1'b0;
        shop_rd_idx = r_j + SW'(1);
        cost_ctl    = '0;
        unique case (r_state)
            S_IDLE: begin
                in_ready           = 1'b1;
                cost_ctl.best_init = fin_acc && go_enum;
                cost_ctl.sum_clear = fin_acc && go_enum;
            end
            S_HOUSE: shop_rd_idx = '0;
            S_DIST: begin
                cost_ctl.dist_en    = 1'b1;
                cost_ctl.dist_first = (r_j == '0);
            end
            S_ACC: cost_ctl.acc_en = 1'b1;
            S_CMP: begin
                cost_ctl.best_upd  = 1'b1;
                cost_ctl.sum_clear = 1'b1;
            end
            S_DONE: out_load = out_free;
            default: ;
        endcase
    end

    // Sequencer registers, counts and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_sel    <= SEL_RESET;
            r_hcnt   <= '0;
            r_scnt   <= '0;
            r_ovf    <= 1'b0;
            r_h      <= '0;
            r_j      <= '0;
            r_i      <= '0;
            r_k      <= '0;
            r_val    <= '0;
            r_ovalid <= 1'b0;
            for (int s = 0; s < MAX_SHOPS; s++) begin
                r_chosen[s] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_sel <= i_cfg.select_count;
            end

            // Load stores, flag drops
            if (house_we) begin
                r_hcnt <= r_hcnt + HCW'(1);
            end
            if (shop_we) begin
                r_scnt <= r_scnt + CW'(1);
            end
            if (in_acc && !house_room && (i_in.action == ACT_HOUSE)) begin
                r_ovf <= 1'b1;
            end
            if (in_acc && !shop_room && (i_in.action == ACT_SHOP)) begin
                r_ovf <= 1'b1;
            end

            // Walk houses, chosen shops and combinations
            unique case (r_state)
                S_IDLE: begin
                    if (fin_acc) begin
                        r_h <= '0;
                        for (int s = 0; s < MAX_SHOPS; s++) begin
                            r_chosen[s] <= SW'(s);
                        end
                    end
                end
                S_HOUSE: r_j <= '0;
                S_DIST: r_j <= r_j + SW'(1);
                S_ACC: begin
                    if (!last_h) begin
                        r_h <= r_h + HW'(1);
                    end
                end
                S_CMP: begin
                    r_h <= '0;
                    r_i <= SW'(m_x - XW'(1));
                end
                S_FIND: begin
                    if (can_adv) begin
                        r_val <= r_chosen[r_i] + SW'(1);
                        r_k   <= r_i;
                    end else begin
                        r_i <= r_i - SW'(1);
                    end
                end
                S_FILL: begin
                    r_chosen[r_k] <= r_val;
                    r_val         <= r_val + SW'(1);
                    r_k           <= r_k + SW'(1);
                end
                S_DONE: begin
                    if (out_free) begin
                        r_hcnt <= '0;
                        r_scnt <= '0;
                        r_ovf  <= 1'b0;
                    end
                end
                default: ;
            endcase

            // Hold the result until the sink takes it
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (fin_acc) begin
            r_fix     <= !go_enum;
            r_nosol   <= nosol_now;
            r_fix_val <= (nosol_now || (r_hcnt == '0)) ? '0 : TOTAL_MAX;
        end
        if (out_load) begin
            r_obest  <= r_fix ? r_fix_val : cost_best;
            r_onosol <= r_nosol;
            r_oovf   <= r_ovf;
        end
    end

    assign i_in.ready          = in_ready;
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_ovalid;
    assign o_out.best_total    = r_obest;
    assign o_out.no_solution   = r_onosol;
    assign o_out.overflow_seen = r_oovf;

    mmfs_ram #(
        .DEPTH (MAX_HOUSES),
        .WIDTH (ENTRY_W)
    ) u_house_ram (
        .i_clk   (i_clk),
        .i_we    (house_we),
        .i_waddr (r_hcnt[HW-1:0]),
        .i_wdata ({i_in.row, i_in.col}),
        .i_raddr (r_h),
        .o_rdata (house_q)
    );

    mmfs_ram #(
        .DEPTH (MAX_SHOPS),
        .WIDTH (ENTRY_W)
    ) u_shop_ram (
        .i_clk   (i_clk),
        .i_we    (shop_we),
        .i_waddr (r_scnt[SW-1:0]),
        .i_wdata ({i_in.row, i_in.col}),
        .i_raddr (r_chosen[shop_rd_idx]),
        .o_rdata (shop_q)
    );

    mmfs_cost u_cost (
        .i_clk   (i_clk),
        .i_ctl   (cost_ctl),
        .i_house (house_q),
        .i_shop  (shop_q),
        .o_best  (cost_best)
    );

endmodule
